>>> rtl/kpd_pkg.sv
`timescale 1ns / 1ps

package kpd_pkg;

  // matrix geometry
  localparam int ROWS      = 6;
  localparam int COLUMNS   = 4;
  localparam int KEY_COUNT = ROWS * COLUMNS;

  // result field widths
  localparam int ROW_W = 3;
  localparam int COL_W = 2;
  localparam int POS_W = 5;

  typedef logic [KEY_COUNT-1:0] key_mask_t;

  // new press mask handed from the detector to the event emitter
  typedef struct packed {
    logic      load;
    key_mask_t mask;
  } pend_load_t;

endpackage

>>> rtl/kpd_detect.sv
`timescale 1ns / 1ps

module kpd_detect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  kpd_pkg::key_mask_t  sample,
  output kpd_pkg::pend_load_t pend
);

  kpd_pkg::key_mask_t prev_r;
  kpd_pkg::key_mask_t prev_nxt;
  kpd_pkg::key_mask_t held_r;
  kpd_pkg::key_mask_t held_nxt;
  kpd_pkg::key_mask_t held_now;

  // held when pressed in two scans in a row
  assign held_now = sample & prev_r;

  always_comb begin
    prev_nxt = prev_r;
    held_nxt = held_r;
    if (accept) begin
      prev_nxt = sample;
      held_nxt = held_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      held_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      held_r <= held_nxt;
    end
  end

  // rising edge of the held state
  assign pend.load = accept;
  assign pend.mask = held_now & ~held_r;

endmodule

>>> rtl/kpd_emit.sv
`timescale 1ns / 1ps

module kpd_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kpd_pkg::pend_load_t       pend,
  output logic                      load_ok,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kpd_pkg::ROW_W-1:0] out_key_row,
  output logic [kpd_pkg::COL_W-1:0] out_key_column,
  output logic [kpd_pkg::POS_W-1:0] out_key_position,
  output logic                      out_last_event
);

  kpd_pkg::key_mask_t pend_r;
  kpd_pkg::key_mask_t pend_nxt;
  kpd_pkg::key_mask_t low_bit;
  kpd_pkg::key_mask_t rest;

  logic                      valid_r;
  logic                      valid_nxt;
  logic [kpd_pkg::ROW_W-1:0] row_r;
  logic [kpd_pkg::ROW_W-1:0] row_nxt;
  logic [kpd_pkg::COL_W-1:0] col_r;
  logic [kpd_pkg::COL_W-1:0] col_nxt;
  logic [kpd_pkg::POS_W-1:0] pos_r;
  logic [kpd_pkg::POS_W-1:0] pos_nxt;
  logic                      last_r;
  logic                      last_nxt;

  logic                      take;
  logic [kpd_pkg::ROW_W-1:0] enc_row;
  logic [kpd_pkg::COL_W-1:0] enc_col;
  logic [kpd_pkg::POS_W-1:0] enc_pos;

  // lowest pending key goes first
  assign low_bit = pend_r & (~pend_r + kpd_pkg::KEY_COUNT'(1));
  assign rest    = pend_r & ~low_bit;
  assign take    = (pend_r != '0) && (!valid_r || out_ready);
  assign load_ok = (pend_r == '0) || (take && (rest == '0));

  always_comb begin
    enc_row = '0;
    enc_col = '0;
    enc_pos = '0;
    for (int r = 0; r < kpd_pkg::ROWS; r++) begin
      for (int c = 0; c < kpd_pkg::COLUMNS; c++) begin
        if (low_bit[r * kpd_pkg::COLUMNS + c]) begin
          enc_row = kpd_pkg::ROW_W'(r);
          enc_col = kpd_pkg::COL_W'(c);
          enc_pos = kpd_pkg::POS_W'(r * kpd_pkg::COLUMNS + c);
        end
      end
    end
  end

  always_comb begin
    pend_nxt  = pend_r;
    valid_nxt = valid_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    if (take) begin
      pend_nxt  = rest;
      valid_nxt = 1'b1;
      row_nxt   = enc_row;
      col_nxt   = enc_col;
      pos_nxt   = enc_pos;
      last_nxt  = (rest == '0);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (pend.load) begin
      pend_nxt = pend.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    pos_r  <= pos_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_key_row      = row_r;
  assign out_key_column   = col_r;
  assign out_key_position = pos_r;
  assign out_last_event   = last_r;

endmodule

>>> rtl/keypad_matrix_press_detector_unit.sv
`timescale 1ns / 1ps
// press events: the first event of a scan is held in the pending-press register and then in the
// output register; events leave at one per cycle while out_ready holds, and a new scan item
//   is taken once the pending presses are empty or the last one is taken
// reset: rst_n synchronous active low, clears previous sample, held mask, pending presses
//   and the output valid

module keypad_matrix_press_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kpd_pkg::KEY_COUNT-1:0]        in_matrix_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [kpd_pkg::ROW_W-1:0]            out_key_row,
  output logic [kpd_pkg::COL_W-1:0]            out_key_column,
  output logic [kpd_pkg::POS_W-1:0]            out_key_position,
  output logic                                 out_last_event
);

  kpd_pkg::pend_load_t pend;
  logic                load_ok;
  logic                accept;

  // a scan is taken whenever the pending mask is empty or drains this cycle
  assign in_ready = load_ok;
  assign accept   = in_valid && load_ok;

  // debounce state and new press mask
  kpd_detect u_detect (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sample (in_matrix_sample),
    .pend   (pend)
  );

  // row-major event walk with output register
  kpd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .pend             (pend),
    .load_ok          (load_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_row      (out_key_row),
    .out_key_column   (out_key_column),
    .out_key_position (out_key_position),
    .out_last_event   (out_last_event)
  );

endmodule
